@@ rtl/rolling_bloom_filter_top_macros.svh @@
// Assertion helpers shared by the RTL. Each use sits on a line of its own.
`ifndef ROLLING_BLOOM_FILTER_TOP_MACROS_SVH
`define ROLLING_BLOOM_FILTER_TOP_MACROS_SVH

// prop must hold at every clock edge out of reset
`define RBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// cond must never be true out of reset
`define RBF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/rbf_pkg.sv @@
// ----------------------------------------------------------------------------
// rbf_pkg
// Codes and hash constants of the rolling Bloom filter.
// ----------------------------------------------------------------------------
package rbf_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_HASH_COUNT = 2'd0,
    CFG_GEN_SIZE   = 2'd1,
    CFG_PAIR_COUNT = 2'd2,
    CFG_HASH_TWEAK = 2'd3
  } cfg_e;

  localparam logic [31:0] SEED_STEP = 32'hFBA4C795;
  localparam logic [31:0] MM_C1     = 32'hCC9E2D51;
  localparam logic [31:0] MM_C2     = 32'h1B873593;
  localparam logic [31:0] MM_ADD    = 32'hE6546B64;
  localparam logic [31:0] MM_FMIX1  = 32'h85EBCA6B;
  localparam logic [31:0] MM_FMIX2  = 32'hC2B2AE35;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

endpackage

@@ rtl/rolling_bloom_filter_top.sv @@
// ----------------------------------------------------------------------------
// rolling_bloom_filter_top
// Three-generation rolling Bloom filter keyed by MurmurHash3 x86_32.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries key chunks or a clear; a beat
// is taken when valid is high and stall is low. Each key chunk is accepted and
// then written into the key word buffer in three word steps. The last chunk of a
// key, and every clear, gives one result beat on the output channel
// (out_valid_o / out_stall_i); other chunks give none.
// For a finished key, each hash walks the key buffer one 32-bit word at a time
// through a single shared 32x32 multiplier, then reads its pair from the pair
// memory and, for an insert, writes it back updated. A clear adds a sweep over
// the whole pair memory; an insert that starts a new generation adds a
// read-back sweep (one pair per cycle) that wipes the new code from every pair.
// After reset the block runs the same clearing pass with in_stall_o high.
// Config writes (cfg_valid_i / cfg_ready_o) are always taken and are meant
// for idle periods.
// A result waits in the output register while the receiver stalls; the block
// keeps taking chunks and only holds before loading the next result.
module rolling_bloom_filter_top #(
  parameter int unsigned MAX_PAIRS     = 1024,
  parameter int unsigned MAX_KEY_BYTES = 64,
  parameter int unsigned MAX_HASHES    = 50
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [63:0] key_bytes_i,
  input  logic [3:0]  byte_count_i,
  input  logic        key_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic        status_o
);

  localparam int unsigned PAIR_AW   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int unsigned SPW       = PAIR_AW + 1;
  localparam int unsigned KEY_WORDS = (MAX_KEY_BYTES + 3) / 4;
  localparam int unsigned KAW       = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int unsigned JW        = KAW + 1;
  localparam int unsigned KLW       = $clog2(MAX_KEY_BYTES + 1);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_KWR   = 13'b0000000000010,
    S_SWEEP = 13'b0000000000100,
    S_HASH  = 13'b0000000001000,
    S_K1    = 13'b0000000010000,
    S_K2    = 13'b0000000100000,
    S_MIX   = 13'b0000001000000,
    S_FIN0  = 13'b0000010000000,
    S_FIN1  = 13'b0000100000000,
    S_FIN2  = 13'b0001000000000,
    S_PRD   = 13'b0010000000000,
    S_PUPD  = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_e;

  // configuration
  logic [5:0]  hcount_q;
  logic [23:0] gsize_q;
  logic [10:0] pcount_q;
  logic [31:0] tweak_q;

  // control and datapath registers
  state_e            state_q, state_d;
  logic [1:0]        gen_q, gen_d;
  logic [23:0]       fill_q, fill_d;
  logic [KLW-1:0]    klen_q, klen_d;
  logic              ovf_q, ovf_d;
  logic              last_q, last_d;
  logic              ins_q, ins_d;
  logic              wr_q, wr_d;
  logic [63:0]       chunk_q, chunk_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [KLW-1:0]    off_q, off_d;
  logic [1:0]        wcnt_q, wcnt_d;
  logic [SPW-1:0]    sp_q, sp_d;
  logic              pend_q, pend_d;
  logic [PAIR_AW-1:0] wa_q, wa_d;
  logic              wipe_q, wipe_d;
  logic              sres_q, sres_d;
  logic [6:0]        n_q, n_d;
  logic [31:0]       seed_q, seed_d;
  logic [31:0]       h_q, h_d;
  logic [31:0]       x_q, x_d;
  logic [JW-1:0]     j_q, j_d;
  logic [PAIR_AW-1:0] pair_q, pair_d;
  logic [5:0]        bit_q, bit_d;
  logic              found_q, found_d;
  logic              res_found_q, res_found_d;
  logic              res_status_q, res_status_d;
  logic              out_valid_q, out_valid_d;
  logic              found_o_q, found_o_d;
  logic              status_o_q, status_o_d;

  // memories
  logic [127:0]      pair_mem [MAX_PAIRS];
  logic [127:0]      pm_rdata_q;
  logic              pm_re, pm_we;
  logic [PAIR_AW-1:0] pm_raddr, pm_waddr;
  logic [127:0]      pm_wdata;

  logic [3:0][7:0]   key_mem [KEY_WORDS];
  logic [31:0]       km_rdata_q;
  logic              km_re;
  logic [3:0]        km_be;
  logic [KAW-1:0]    km_raddr, km_waddr;
  logic [31:0]       km_wdata;

  // shared multiplier
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;

  // helpers
  logic [3:0]        cnt_eff;
  logic [8:0]        room;
  logic              over;
  logic [95:0]       win;
  logic [11:0]       be12;
  logic [KAW+1:0]    kaddr;
  logic [KLW:0]      l3;
  logic [JW-1:0]     nwords, blocks;
  logic              tail;
  logic [31:0]       kmask, t0, t1, mixr;
  logic [31:0]       pairs_eff, span;
  logic [6:0]        hc7, nh;
  logic [63:0]       lo_w, hi_w, keep, onebit;
  logic [63:0]       m1, m2;
  logic              accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign found_o     = found_o_q;
  assign status_o    = status_o_q;

  assign prod = {32'b0, mul_a} * {32'b0, mul_b};

  always_comb begin
    hc7 = {1'b0, hcount_q};
    if (hcount_q == 6'd0) begin
      nh = 7'd1;
    end else if (hc7 > 7'(MAX_HASHES)) begin
      nh = 7'(MAX_HASHES);
    end else begin
      nh = hc7;
    end
    if (pcount_q == 11'd0) begin
      pairs_eff = 32'd1;
    end else if ({21'b0, pcount_q} > 32'(MAX_PAIRS)) begin
      pairs_eff = 32'(MAX_PAIRS);
    end else begin
      pairs_eff = {21'b0, pcount_q};
    end
    span = {pairs_eff[30:0], 1'b0};
  end

  always_comb begin
    cnt_eff = (byte_count_i > 4'd8) ? 4'd8 : byte_count_i;
    room    = 9'(MAX_KEY_BYTES) - 9'(klen_q);
    over    = ({5'b0, cnt_eff} > room);
    win     = {32'b0, chunk_q} << {off_q[1:0], 3'b000};
    be12    = (~(12'hFFF << cnt_q)) << off_q[1:0];
    kaddr   = (KAW + 2)'(off_q >> 2) + (KAW + 2)'(wcnt_q);
    l3      = {1'b0, klen_q} + (KLW + 1)'(3);
    nwords  = JW'(l3 >> 2);
    blocks  = JW'(klen_q >> 2);
    tail    = (j_q == blocks);
    kmask   = tail ? ~(32'hFFFFFFFF << {klen_q[1:0], 3'b000}) : 32'hFFFFFFFF;
    lo_w    = pm_rdata_q[63:0];
    hi_w    = pm_rdata_q[127:64];
    m1      = {64{gen_q[0]}};
    m2      = {64{gen_q[1]}};
    keep    = (lo_w ^ m1) | (hi_w ^ m2);
    onebit  = 64'd1 << bit_q;
    t0      = h_q ^ x_q;
    mixr    = rbf_pkg::rotl32(t0, 13);
    t1      = (h_q ^ 32'(klen_q));
  end

  always_comb begin
    state_d      = state_q;
    gen_d        = gen_q;
    fill_d       = fill_q;
    klen_d       = klen_q;
    ovf_d        = ovf_q;
    last_d       = last_q;
    ins_d        = ins_q;
    wr_d         = wr_q;
    chunk_d      = chunk_q;
    cnt_d        = cnt_q;
    off_d        = off_q;
    wcnt_d       = wcnt_q;
    sp_d         = sp_q;
    pend_d       = pend_q;
    wa_d         = wa_q;
    wipe_d       = wipe_q;
    sres_d       = sres_q;
    n_d          = n_q;
    seed_d       = seed_q;
    h_d          = h_q;
    x_d          = x_q;
    j_d          = j_q;
    pair_d       = pair_q;
    bit_d        = bit_q;
    found_d      = found_q;
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    found_o_d    = found_o_q;
    status_o_d   = status_o_q;
    pm_re        = 1'b0;
    pm_we        = 1'b0;
    pm_raddr     = pair_q;
    pm_waddr     = pair_q;
    pm_wdata     = '0;
    km_re        = 1'b0;
    km_be        = 4'b0;
    km_raddr     = j_q[KAW-1:0];
    km_waddr     = kaddr[KAW-1:0];
    km_wdata     = win[32*wcnt_q +: 32];
    mul_a        = x_q;
    mul_b        = rbf_pkg::MM_C2;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_i)
            rbf_pkg::OP_CLEAR: begin
              gen_d   = 2'd1;
              fill_d  = '0;
              klen_d  = '0;
              ovf_d   = 1'b0;
              wipe_d  = 1'b0;
              sres_d  = 1'b1;
              sp_d    = '0;
              pend_d  = 1'b0;
              state_d = S_SWEEP;
            end
            rbf_pkg::OP_INSERT, rbf_pkg::OP_QUERY: begin
              chunk_d = key_bytes_i;
              cnt_d   = cnt_eff;
              off_d   = klen_q;
              wr_d    = !ovf_q && !over;
              ovf_d   = ovf_q || over;
              if (!ovf_q && !over) begin
                klen_d = klen_q + KLW'(cnt_eff);
              end
              last_d  = key_last_i;
              ins_d   = (op_i == rbf_pkg::OP_INSERT);
              wcnt_d  = '0;
              state_d = S_KWR;
            end
            default: begin
            end
          endcase
        end
      end
      S_KWR: begin
        km_be  = be12[4*wcnt_q +: 4] & {4{wr_q}};
        wcnt_d = wcnt_q + 2'd1;
        if (wcnt_q == 2'd2) begin
          if (!last_q) begin
            state_d = S_IDLE;
          end else if (ovf_q) begin
            res_found_d  = 1'b0;
            res_status_d = 1'b1;
            klen_d       = '0;
            ovf_d        = 1'b0;
            state_d      = S_OUT;
          end else begin
            if (ins_q && (fill_q >= gsize_q)) begin
              gen_d   = (gen_q == 2'd3) ? 2'd1 : gen_q + 2'd1;
              fill_d  = 24'd1;
              wipe_d  = 1'b1;
              sres_d  = 1'b0;
              sp_d    = '0;
              pend_d  = 1'b0;
              state_d = S_SWEEP;
            end else begin
              if (ins_q) begin
                fill_d = fill_q + 24'd1;
              end
              n_d     = '0;
              seed_d  = tweak_q;
              h_d     = tweak_q;
              j_d     = '0;
              found_d = 1'b1;
              state_d = S_HASH;
            end
          end
        end
      end
      S_SWEEP: begin
        if (wipe_q) begin
          // read pair p, write it back in the next cycle with the new code wiped
          pend_d = 1'b0;
          if (sp_q != SPW'(MAX_PAIRS)) begin
            pm_re    = 1'b1;
            pm_raddr = sp_q[PAIR_AW-1:0];
            sp_d     = sp_q + SPW'(1);
            pend_d   = 1'b1;
            wa_d     = sp_q[PAIR_AW-1:0];
          end
          if (pend_q) begin
            pm_we    = 1'b1;
            pm_waddr = wa_q;
            pm_wdata = {hi_w & keep, lo_w & keep};
          end
          if ((sp_q == SPW'(MAX_PAIRS)) && !pend_q) begin
            n_d     = '0;
            seed_d  = tweak_q;
            h_d     = tweak_q;
            j_d     = '0;
            found_d = 1'b1;
            state_d = S_HASH;
          end
        end else begin
          if (sp_q != SPW'(MAX_PAIRS)) begin
            pm_we    = 1'b1;
            pm_waddr = sp_q[PAIR_AW-1:0];
            pm_wdata = '0;
            sp_d     = sp_q + SPW'(1);
          end else if (sres_q) begin
            res_found_d  = 1'b0;
            res_status_d = 1'b0;
            state_d      = S_OUT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_HASH: begin
        if (j_q == nwords) begin
          state_d = S_FIN0;
        end else begin
          km_re   = 1'b1;
          state_d = S_K1;
        end
      end
      S_K1: begin
        mul_a   = km_rdata_q & kmask;
        mul_b   = rbf_pkg::MM_C1;
        x_d     = prod[31:0];
        state_d = S_K2;
      end
      S_K2: begin
        mul_a   = rbf_pkg::rotl32(x_q, 15);
        mul_b   = rbf_pkg::MM_C2;
        x_d     = prod[31:0];
        state_d = S_MIX;
      end
      S_MIX: begin
        // partial tail word only xors in
        if (tail) begin
          h_d = t0;
        end else begin
          h_d = mixr + {mixr[29:0], 2'b00} + rbf_pkg::MM_ADD;
        end
        j_d     = j_q + JW'(1);
        state_d = S_HASH;
      end
      S_FIN0: begin
        mul_a   = t1 ^ (t1 >> 16);
        mul_b   = rbf_pkg::MM_FMIX1;
        x_d     = prod[31:0];
        state_d = S_FIN1;
      end
      S_FIN1: begin
        mul_a   = x_q ^ (x_q >> 13);
        mul_b   = rbf_pkg::MM_FMIX2;
        x_d     = prod[31:0];
        state_d = S_FIN2;
      end
      S_FIN2: begin
        mul_a   = x_q ^ (x_q >> 16);
        mul_b   = span;
        pair_d  = prod[33 +: PAIR_AW];
        bit_d   = mul_a[5:0];
        state_d = S_PRD;
      end
      S_PRD: begin
        pm_re    = 1'b1;
        pm_raddr = pair_q;
        state_d  = S_PUPD;
      end
      S_PUPD: begin
        if (ins_q) begin
          pm_we    = 1'b1;
          pm_waddr = pair_q;
          pm_wdata = {(hi_w & ~onebit) | (64'(gen_q[1]) << bit_q),
                      (lo_w & ~onebit) | (64'(gen_q[0]) << bit_q)};
        end else begin
          found_d = found_q && ((lo_w[bit_q] | hi_w[bit_q]) == 1'b1);
        end
        n_d    = n_q + 7'd1;
        seed_d = seed_q + rbf_pkg::SEED_STEP;
        h_d    = seed_q + rbf_pkg::SEED_STEP;
        j_d    = '0;
        if ((n_q + 7'd1) == nh) begin
          res_found_d  = !ins_q && found_d;
          res_status_d = 1'b0;
          klen_d       = '0;
          ovf_d        = 1'b0;
          state_d      = S_OUT;
        end else begin
          state_d = S_HASH;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          found_o_d   = res_found_q;
          status_o_d  = res_status_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcount_q <= 6'd1;
      gsize_q  <= 24'd1024;
      pcount_q <= 11'd1024;
      tweak_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rbf_pkg::CFG_HASH_COUNT: hcount_q <= cfg_data_i[5:0];
        rbf_pkg::CFG_GEN_SIZE:   gsize_q  <= cfg_data_i[23:0];
        rbf_pkg::CFG_PAIR_COUNT: pcount_q <= cfg_data_i[10:0];
        rbf_pkg::CFG_HASH_TWEAK: tweak_q  <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      gen_q       <= 2'd1;
      fill_q      <= '0;
      klen_q      <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      ins_q       <= 1'b0;
      wr_q        <= 1'b0;
      wcnt_q      <= '0;
      sp_q        <= '0;
      pend_q      <= 1'b0;
      wipe_q      <= 1'b0;
      sres_q      <= 1'b0;
      n_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      fill_q      <= fill_d;
      klen_q      <= klen_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      ins_q       <= ins_d;
      wr_q        <= wr_d;
      wcnt_q      <= wcnt_d;
      sp_q        <= sp_d;
      pend_q      <= pend_d;
      wipe_q      <= wipe_d;
      sres_q      <= sres_d;
      n_q         <= n_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chunk_q      <= chunk_d;
    cnt_q        <= cnt_d;
    off_q        <= off_d;
    wa_q         <= wa_d;
    seed_q       <= seed_d;
    h_q          <= h_d;
    x_q          <= x_d;
    pair_q       <= pair_d;
    bit_q        <= bit_d;
    found_q      <= found_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
    found_o_q    <= found_o_d;
    status_o_q   <= status_o_d;
  end

  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      pair_mem[pm_waddr] <= pm_wdata;
    end
    if (pm_re) begin
      pm_rdata_q <= pair_mem[pm_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 4; b++) begin
      if (km_be[b]) begin
        key_mem[km_waddr][b] <= km_wdata[8*b +: 8];
      end
    end
    if (km_re) begin
      km_rdata_q <= key_mem[km_raddr];
    end
  end

`include "rolling_bloom_filter_top_macros.svh"

  `RBF_ASSERT(a_sweep_stalls, (state_q != S_SWEEP) || in_stall_o, "input taken during sweep")
  `RBF_ASSERT(a_upd_after_rd, (state_q != S_PUPD) || $past(state_q == S_PRD), "pair update w/o read")
  `RBF_ASSERT_NEVER(a_rw_same, pm_re && pm_we && (pm_raddr == pm_waddr), "pair read/write clash")
  `RBF_ASSERT_NEVER(a_ovf_found, out_valid_q && status_o_q && found_o_q, "overflow beat found")

endmodule
